@@ hdl/amou_pkg.sv @@
package amou_pkg;

	localparam int unsigned XLEN = 64;

	// funct5 operation codes
	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SWAP = 5'd1;
	localparam logic [4:0] OP_LR   = 5'd2;
	localparam logic [4:0] OP_SC   = 5'd3;
	localparam logic [4:0] OP_XOR  = 5'd4;
	localparam logic [4:0] OP_OR   = 5'd8;
	localparam logic [4:0] OP_AND  = 5'd12;
	localparam logic [4:0] OP_MIN  = 5'd16;
	localparam logic [4:0] OP_MAX  = 5'd20;
	localparam logic [4:0] OP_MINU = 5'd24;
	localparam logic [4:0] OP_MAXU = 5'd28;

	// funct3 width codes
	localparam logic [2:0] WID_WORD   = 3'd2;
	localparam logic [2:0] WID_DOUBLE = 3'd3;

	// trap codes
	localparam logic [2:0] TRAP_NONE        = 3'd0;
	localparam logic [2:0] TRAP_ILLEGAL     = 3'd1;
	localparam logic [2:0] TRAP_LD_MISALIGN = 3'd2;
	localparam logic [2:0] TRAP_ST_MISALIGN = 3'd3;
	localparam logic [2:0] TRAP_XLATE       = 3'd4;

	typedef struct packed {
		logic [2:0]      trap_kind;
		logic [XLEN-1:0] trap_value;
		logic            mem_write;
		logic            mem_write_double;
		logic [XLEN-1:0] mem_wdata;
		logic            rd_write;
		logic [XLEN-1:0] rd_value;
	} amou_result_t;

	// reservation update requested by one instruction
	typedef struct packed {
		logic set;
		logic clear;
		logic dbl;
	} amou_rsv_upd_t;

endpackage

@@ hdl/amou_exec.sv @@
module amou_exec
	import amou_pkg::*;
#(
	parameter int unsigned PADDR_BITS = 56
) (
	input  logic [4:0]            req_type,
	input  logic [2:0]            width_code,
	input  logic [4:0]            src2_index,
	input  logic [31:0]           raw_instr,
	input  logic [XLEN-1:0]       virt_addr,
	input  logic                  xlate_ok,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [XLEN-1:0]       mem_old,
	input  logic [XLEN-1:0]       src2_value,
	input  logic                  rsv_valid,
	input  logic [PADDR_BITS-1:0] rsv_addr,
	input  logic                  rsv_dbl,
	output amou_result_t          result,
	output amou_rsv_upd_t         rsv_upd
);

	localparam logic [PADDR_BITS-1:0] SZ_WORD   = PADDR_BITS'(4);
	localparam logic [PADDR_BITS-1:0] SZ_DOUBLE = PADDR_BITS'(8);

	logic            is_amo;
	logic            dbl;
	logic [XLEN-1:0] old_op;
	logic [XLEN-1:0] rhs_op;
	logic [XLEN-1:0] sign_mask;
	logic            old_lt;
	logic [XLEN-1:0] amo_val;
	logic [XLEN-1:0] old_sext;
	logic [XLEN-1:0] src2_word;
	logic            sc_match;
	logic [PADDR_BITS-1:0] my_size;
	logic [PADDR_BITS-1:0] rsv_size;
	logic [PADDR_BITS-1:0] diff_pr;
	logic [PADDR_BITS-1:0] diff_rp;
	logic            overlap;

	always_comb begin
		case (req_type)
			OP_ADD, OP_SWAP, OP_XOR, OP_OR, OP_AND,
			OP_MIN, OP_MAX, OP_MINU, OP_MAXU: is_amo = 1'b1;
			default: is_amo = 1'b0;
		endcase
	end

	assign dbl       = (width_code == WID_DOUBLE);
	assign src2_word = {32'b0, src2_value[31:0]};
	assign old_sext  = {{32{mem_old[31]}}, mem_old[31:0]};
	assign old_op    = dbl ? mem_old : {32'b0, mem_old[31:0]};
	assign rhs_op    = dbl ? src2_value : src2_word;

	// signed compares flip the top bit of the active width
	always_comb begin
		sign_mask = '0;
		if (req_type == OP_MIN || req_type == OP_MAX) begin
			if (dbl)
				sign_mask[XLEN-1] = 1'b1;
			else
				sign_mask[31] = 1'b1;
		end
	end

	assign old_lt = (old_op ^ sign_mask) < (rhs_op ^ sign_mask);

	always_comb begin
		case (req_type)
			OP_SWAP: amo_val = rhs_op;
			OP_ADD:  amo_val = old_op + rhs_op;
			OP_XOR:  amo_val = old_op ^ rhs_op;
			OP_AND:  amo_val = old_op & rhs_op;
			OP_OR:   amo_val = old_op | rhs_op;
			OP_MIN, OP_MINU: amo_val = old_lt ? old_op : rhs_op;
			default: amo_val = old_lt ? rhs_op : old_op;
		endcase
		if (!dbl)
			amo_val[XLEN-1:32] = '0;
	end

	assign sc_match = rsv_valid && (rsv_addr == paddr) && (rsv_dbl == dbl);

	// byte ranges [pa, pa+size) and [rsv, rsv+size) meet
	assign my_size  = dbl ? SZ_DOUBLE : SZ_WORD;
	assign rsv_size = rsv_dbl ? SZ_DOUBLE : SZ_WORD;
	assign diff_pr  = paddr - rsv_addr;
	assign diff_rp  = rsv_addr - paddr;
	assign overlap  = (paddr >= rsv_addr) ? (diff_pr < rsv_size) : (diff_rp < my_size);

	always_comb begin
		result  = '0;
		rsv_upd = '0;
		rsv_upd.dbl = dbl;
		if (!is_amo && req_type != OP_LR && req_type != OP_SC) begin
			result.trap_kind  = TRAP_ILLEGAL;
			result.trap_value = {32'b0, raw_instr};
		end else if (width_code != WID_WORD && width_code != WID_DOUBLE) begin
			result.trap_kind  = TRAP_ILLEGAL;
			result.trap_value = {32'b0, raw_instr};
		end else if (req_type == OP_LR && src2_index != 5'd0) begin
			result.trap_kind  = TRAP_ILLEGAL;
			result.trap_value = {32'b0, raw_instr};
		end else if ((virt_addr[1:0] != 2'b00) || (dbl && virt_addr[2])) begin
			result.trap_kind  = (req_type == OP_LR) ? TRAP_LD_MISALIGN : TRAP_ST_MISALIGN;
			result.trap_value = virt_addr;
		end else if (!xlate_ok) begin
			result.trap_kind  = TRAP_XLATE;
			result.trap_value = virt_addr;
		end else if (req_type == OP_LR) begin
			result.rd_write = 1'b1;
			result.rd_value = dbl ? mem_old : old_sext;
			rsv_upd.set     = 1'b1;
		end else if (req_type == OP_SC) begin
			result.rd_write = 1'b1;
			rsv_upd.clear   = 1'b1;
			if (sc_match) begin
				result.mem_write        = 1'b1;
				result.mem_write_double = dbl;
				result.mem_wdata        = dbl ? src2_value : src2_word;
			end else begin
				result.rd_value = XLEN'(1);
			end
		end else begin
			result.mem_write        = 1'b1;
			result.mem_write_double = dbl;
			result.mem_wdata        = amo_val;
			result.rd_write         = 1'b1;
			result.rd_value         = dbl ? mem_old : old_sext;
			rsv_upd.clear           = rsv_valid && overlap;
		end
	end

endmodule

@@ hdl/atomic_memory_op_unit_core.sv @@
// an accepted beat is held in the input register, then in the result register that drives the outputs
// throughput: one instruction per cycle while out_stall is low, input register feeds result register
// the output register frees the input side while a result waits to be taken
// reservation is read and updated as an instruction moves into the result register
// reset clears both stage valids and the reservation; payload registers are not reset
module atomic_memory_op_unit_core
	import amou_pkg::*;
#(
	parameter int unsigned PADDR_BITS = 56
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [4:0]            req_type,
	input  logic [2:0]            width_code,
	input  logic [4:0]            src2_index,
	input  logic [31:0]           raw_instr,
	input  logic [XLEN-1:0]       virt_addr,
	input  logic                  xlate_ok,
	input  logic [PADDR_BITS-1:0] paddr,
	input  logic [XLEN-1:0]       mem_old,
	input  logic [XLEN-1:0]       src2_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            trap_kind,
	output logic [XLEN-1:0]       trap_value,
	output logic                  mem_write,
	output logic                  mem_write_double,
	output logic [XLEN-1:0]       mem_wdata,
	output logic                  rd_write,
	output logic [XLEN-1:0]       rd_value
);

	logic                  valid_s1;
	logic [4:0]            req_type_s1;
	logic [2:0]            width_code_s1;
	logic [4:0]            src2_index_s1;
	logic [31:0]           raw_instr_s1;
	logic [XLEN-1:0]       virt_addr_s1;
	logic                  xlate_ok_s1;
	logic [PADDR_BITS-1:0] paddr_s1;
	logic [XLEN-1:0]       mem_old_s1;
	logic [XLEN-1:0]       src2_value_s1;

	logic                  valid_s2;
	amou_result_t          res_s2;

	logic                  rsv_valid_q;
	logic [PADDR_BITS-1:0] rsv_addr_q;
	logic                  rsv_dbl_q;

	amou_result_t          res_d;
	amou_rsv_upd_t         rsv_upd;
	logic                  adv_s1;
	logic                  load_s1;

	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign load_s1  = in_valid && !in_stall;

	amou_exec #(
		.PADDR_BITS(PADDR_BITS)
	) u_exec (
		.req_type  (req_type_s1),
		.width_code(width_code_s1),
		.src2_index(src2_index_s1),
		.raw_instr (raw_instr_s1),
		.virt_addr (virt_addr_s1),
		.xlate_ok  (xlate_ok_s1),
		.paddr     (paddr_s1),
		.mem_old   (mem_old_s1),
		.src2_value(src2_value_s1),
		.rsv_valid (rsv_valid_q),
		.rsv_addr  (rsv_addr_q),
		.rsv_dbl   (rsv_dbl_q),
		.result    (res_d),
		.rsv_upd   (rsv_upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			req_type_s1   <= req_type;
			width_code_s1 <= width_code;
			src2_index_s1 <= src2_index;
			raw_instr_s1  <= raw_instr;
			virt_addr_s1  <= virt_addr;
			xlate_ok_s1   <= xlate_ok;
			paddr_s1      <= paddr;
			mem_old_s1    <= mem_old;
			src2_value_s1 <= src2_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_valid_q <= 1'b0;
			rsv_addr_q  <= '0;
			rsv_dbl_q   <= 1'b0;
		end else if (adv_s1) begin
			if (rsv_upd.set) begin
				rsv_valid_q <= 1'b1;
				rsv_addr_q  <= paddr_s1;
				rsv_dbl_q   <= rsv_upd.dbl;
			end else if (rsv_upd.clear) begin
				rsv_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid        = valid_s2;
	assign trap_kind        = res_s2.trap_kind;
	assign trap_value       = res_s2.trap_value;
	assign mem_write        = res_s2.mem_write;
	assign mem_write_double = res_s2.mem_write_double;
	assign mem_wdata        = res_s2.mem_wdata;
	assign rd_write         = res_s2.rd_write;
	assign rd_value         = res_s2.rd_value;

	// a trapped instruction never writes memory
	a_trap_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mem_write |-> trap_kind == TRAP_NONE)
		else $error("memory write on a trapped instruction");

	a_dbl_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mem_write_double |-> mem_write)
		else $error("doubleword flag without a write");

	// any sc that completes without a trap leaves no reservation behind
	a_sc_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && req_type_s1 == OP_SC && res_d.trap_kind == TRAP_NONE |=> !rsv_valid_q)
		else $error("reservation survived an sc");

	a_lr_sets: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && req_type_s1 == OP_LR && res_d.trap_kind == TRAP_NONE
		|=> rsv_valid_q && rsv_addr_q == $past(paddr_s1))
		else $error("lr did not set the reservation");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with room in the pipe");

endmodule
